// File: hdl/ses_pkg.sv
// Shared types and codes for the sound effect sequencer.
// Holds the command and register-write item types; no dependencies.
package ses_pkg;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_PLAY = 2'd1;
	localparam logic [1:0] ACT_STOP = 2'd2;
	localparam logic [1:0] ACT_LOAD = 2'd3;

	localparam logic [1:0] REG_L = 2'd0;
	localparam logic [1:0] REG_H = 2'd1;
	localparam logic [1:0] REG_X = 2'd2;

	localparam logic [7:0] MARK_RESTART = 8'hFE;
	localparam logic [7:0] MARK_END     = 8'hFF;
	localparam logic [7:0] IDLE_COUNT   = 8'hFF;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  priority_req;
		logic [9:0]  address;
		logic [15:0] load_data;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  channel_register;
		logic [15:0] write_value;
		logic        last;
	} reg_write_t;

endpackage

// File: hdl/sound_effect_sequencer_top.sv
// Sound effect sequencer: sequence memory, playback sequencer and output register.
// Depends on ses_pkg for the item types and the action and register codes.
//
//  channel    | valid      | stall      | item
//  -----------+------------+------------+---------------------------
//  command    | cmd_valid  | cmd_stall  | cmd (action, prio, addr, data)
//  reg write  | reg_valid  | reg_stall  | reg_write (register, value, last)
//
// One command at a time. Stop and idle or counting ticks return from S_PREP to S_IDLE.
// Play and load first subtract SEQ_DEPTH in S_PREP as often as needed to wrap the
// address (never when SEQ_DEPTH >= 1024). A fetch tick is paced by the
// single memory read port (one word per fetch and wait pair); a restart refetches the head at the base address.
// Reset clears control state only; the memory holds garbage until loaded. A stall
// on reg_stall holds the sequencer until the output register frees.
module sound_effect_sequencer_top #(
	parameter int SEQ_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  ses_pkg::cmd_t     cmd,
	output logic              reg_valid,
	input  logic              reg_stall,
	output ses_pkg::reg_write_t reg_write
);
	import ses_pkg::*;

	localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam logic [16:0] DEPTH_W = 17'(SEQ_DEPTH);
	localparam logic [AW-1:0] PTR_MAX = AW'(SEQ_DEPTH - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP  = 6'b000010,
		S_FETCH = 6'b000100,
		S_HEAD  = 6'b001000,
		S_WORD  = 6'b010000,
		S_SIL   = 6'b100000
	} state_t;

	state_t      state_q;
	logic [1:0]  action_q;
	logic [7:0]  prio_in_q;
	logic [15:0] data_q;
	logic [9:0]  red_q;
	logic [AW-1:0] play_q;
	logic [AW-1:0] base_q;
	logic [7:0]  count_q;
	logic [7:0]  cur_prio_q;
	logic [7:0]  dur_q;
	logic [1:0]  idx_q;
	logic        restart_q;
	logic        reg_valid_q;
	reg_write_t  reg_write_q;
	logic [15:0] rdata_q;
	logic [15:0] mem [SEQ_DEPTH];

	logic        can_emit;
	logic        emit;
	reg_write_t  emit_item;
	logic        need_reduce;
	logic        mem_we;
	logic [AW-1:0] addr_red;
	logic [AW-1:0] play_inc;
	logic [7:0]  head_byte;

	assign can_emit    = !reg_valid_q || !reg_stall;
	assign need_reduce = ({7'b0, red_q} >= DEPTH_W);
	assign addr_red    = AW'(red_q);
	assign play_inc    = (play_q == PTR_MAX) ? '0 : play_q + AW'(1);
	assign head_byte   = rdata_q[15:8];
	assign mem_we      = (state_q == S_PREP) && (action_q == ACT_LOAD) && !need_reduce;
	assign cmd_stall   = (state_q != S_IDLE);
	assign reg_valid   = reg_valid_q;
	assign reg_write   = reg_write_q;

	always_comb begin
		emit = 1'b0;
		emit_item = '0;
		unique case (state_q)
			S_HEAD: begin
				if (head_byte != MARK_RESTART && head_byte != MARK_END && can_emit) begin
					emit = 1'b1;
					emit_item = '{channel_register: REG_X, write_value: 16'd0, last: 1'b0};
				end
			end
			S_WORD: begin
				// word index doubles as the register code
				if (can_emit) begin
					emit = 1'b1;
					emit_item = '{channel_register: idx_q, write_value: rdata_q,
						last: (idx_q == REG_X)};
				end
			end
			S_SIL: begin
				if (can_emit) begin
					emit = 1'b1;
					emit_item = '{channel_register: idx_q, write_value: 16'd0,
						last: (idx_q == REG_X)};
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_red] <= data_q;
		end
		rdata_q <= mem[play_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_valid_q <= 1'b0;
		end else if (emit) begin
			reg_valid_q <= 1'b1;
		end else if (!reg_stall) begin
			reg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			reg_write_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			action_q   <= ACT_TICK;
			prio_in_q  <= '0;
			data_q     <= '0;
			red_q      <= '0;
			play_q     <= '0;
			base_q     <= '0;
			count_q    <= IDLE_COUNT;
			cur_prio_q <= '0;
			dur_q      <= '0;
			idx_q      <= REG_L;
			restart_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						action_q  <= cmd.action;
						prio_in_q <= cmd.priority_req;
						data_q    <= cmd.load_data;
						red_q     <= cmd.address;
						state_q   <= S_PREP;
					end
				end
				S_PREP: begin
					if ((action_q == ACT_PLAY || action_q == ACT_LOAD) && need_reduce) begin
						// wrap the address one depth at a time
						red_q <= red_q - 10'(SEQ_DEPTH);
					end else begin
						unique case (action_q)
							ACT_TICK: begin
								if (count_q == IDLE_COUNT) begin
									state_q <= S_IDLE;
								end else if (count_q != 8'd0) begin
									count_q <= count_q - 8'd1;
									state_q <= S_IDLE;
								end else begin
									restart_q <= 1'b0;
									state_q   <= S_FETCH;
								end
							end
							ACT_PLAY: begin
								if (!(cur_prio_q > prio_in_q && count_q != IDLE_COUNT)) begin
									play_q     <= addr_red;
									base_q     <= addr_red;
									count_q    <= 8'd0;
									cur_prio_q <= prio_in_q;
								end
								state_q <= S_IDLE;
							end
							ACT_STOP: begin
								cur_prio_q <= '0;
								count_q    <= IDLE_COUNT;
								state_q    <= S_IDLE;
							end
							ACT_LOAD: begin
								state_q <= S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_FETCH: begin
					// let rdata_q pick up the word at play_q
					state_q <= (idx_q == REG_L && !restart_q) || (idx_q == REG_L) ? S_HEAD : S_WORD;
				end
				S_HEAD: begin
					priority if (head_byte == MARK_RESTART && !restart_q) begin
						restart_q <= 1'b1;
						play_q    <= base_q;
						state_q   <= S_FETCH;
					end else if (head_byte == MARK_RESTART || head_byte == MARK_END) begin
						idx_q   <= REG_L;
						state_q <= S_SIL;
					end else if (can_emit) begin
						dur_q   <= head_byte;
						idx_q   <= REG_L;
						state_q <= S_WORD;
					end else begin
						// hold until the output register frees
						state_q <= S_HEAD;
					end
				end
				S_WORD: begin
					if (can_emit) begin
						play_q <= play_inc;
						if (idx_q == REG_X) begin
							count_q <= dur_q - 8'd1;
							idx_q   <= REG_L;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_FETCH;
						end
					end
				end
				S_SIL: begin
					if (can_emit) begin
						if (idx_q == REG_X) begin
							count_q <= IDLE_COUNT;
							idx_q   <= REG_L;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
